// ===== sv/pfde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfde_pkg;

  // Operation codes of the command port
  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_BAND  = 3'd1,
    OP_LINE  = 3'd2,
    OP_RECT  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_TOP    = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_INVERT = 2'd3
  } cfg_reg_t;

  localparam int          BAND_ROWS      = 8;
  localparam logic [7:0]  FULL_MASK      = 8'hFF;
  localparam logic [6:0]  WIN_RIGHT_INIT = 7'd127;
  localparam int          ROW_GROUPS     = 32;  // 8-bit row / 8 rows per page

endpackage

`default_nettype wire

// ===== sv/page_framebuffer_draw_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Next line, zero-width rectangle, out-of-range read and unused codes raise the done beat
// straight from idle; a byte read passes through S_RDWAIT; pixels and fills walk S_BAND
// per band, then S_COL and S_WR per column byte, a clipped band ending at S_COL.
// Throughput: one command at a time, busy until the done beat; the read-modify-write of
// the single frame store RAM sets the rate. The receiver cannot stall the done beat.
// Reset: synchronous; clears the store, busy high, taking configuration writes as it goes.

module page_framebuffer_draw_engine_unit #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] operation,
  input  wire logic [6:0] pos_x,
  input  wire logic [5:0] pos_y,
  input  wire logic [7:0] fill_width,
  input  wire logic [6:0] fill_height,
  input  wire logic       pixel_on,
  input  wire logic [9:0] read_address,
  input  wire logic       wr_en,
  input  wire logic [1:0] wr_index,
  input  wire logic [6:0] wr_data,
  output logic            done,
  output logic [7:0]      read_data,
  output logic [7:0]      cursor_col,
  output logic [7:0]      cursor_row
);

  import pfde_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  function automatic logic [ROW_GROUPS*PW-1:0] build_page_lut();
    logic [ROW_GROUPS*PW-1:0] lut;
    lut = '0;
    for (int i = 0; i < ROW_GROUPS; i++) begin
      lut[i*PW +: PW] = PW'(i % PAGES);
    end
    return lut;
  endfunction

  localparam logic [ROW_GROUPS*PW-1:0] PAGE_LUT = build_page_lut();

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BAND,
    S_COL,
    S_WR,
    S_RDWAIT
  } state_t;

  state_t state;

  logic [6:0] win_left;
  logic [6:0] win_right;
  logic       win_invert;
  logic [7:0] cursor_x;
  logic [7:0] cursor_y;

  // band walk registers
  op_t        op_q;
  logic [7:0] x_base;
  logic [7:0] y;
  logic [7:0] w;
  logic [6:0] h;
  logic       on_q;
  logic [7:0] mask;
  logic [PW-1:0] pg;
  logic [7:0] c;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] col_addr;
  logic [8:0]    col;
  logic          col_in;
  logic [7:0]    rdata;
  logic [7:0]    mod_data;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  logic [2:0] sft;
  logic [3:0] room;
  logic [3:0] blk;
  logic [7:0] band_mask;
  logic [7:0] nx;
  logic       won;

  assign busy       = (state != S_IDLE);
  assign cursor_col = cursor_x;
  assign cursor_row = cursor_y;
  assign won        = pixel_on ^ win_invert;

  assign col      = {1'b0, x_base} + {1'b0, c};
  assign col_in   = (32'(col) < COLUMNS);
  assign col_addr = AW'(pg * COLUMNS) + AW'(col);
  assign rd_addr  = (state == S_COL) ? col_addr : AW'(read_address);

  assign mod_data  = on_q ? (rdata | mask) : (rdata & ~mask);
  assign ram_we    = (state == S_CLEAR) || (state == S_WR);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
  assign ram_wdata = (state == S_CLEAR) ? 8'd0 : mod_data;

  // band rows: what is left of this page, capped by the rows still to fill
  assign sft       = y[2:0];
  assign room      = 4'(BAND_ROWS) - {1'b0, sft};
  assign blk       = ({1'b0, h} < {4'd0, room}) ? h[3:0] : room;
  assign band_mask = (FULL_MASK >> (4'(BAND_ROWS) - blk)) << sft;
  assign nx        = cursor_x + 8'd1;

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      done       <= 1'b0;
      win_left   <= '0;
      win_right  <= WIN_RIGHT_INIT;
      win_invert <= 1'b0;
      cursor_x   <= '0;
      cursor_y   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (operation)
              OP_PIXEL: begin
                op_q   <= OP_PIXEL;
                x_base <= cursor_x;
                y      <= cursor_y;
                w      <= 8'd1;
                h      <= 7'd1;
                on_q   <= won;
                state  <= S_BAND;
              end
              OP_BAND: begin
                op_q   <= OP_BAND;
                x_base <= cursor_x;
                y      <= cursor_y;
                w      <= fill_width;
                h      <= fill_height;
                on_q   <= won;
                state  <= S_BAND;
              end
              OP_LINE: begin
                if (cursor_x != {1'b0, win_left}) begin
                  cursor_y <= cursor_y + 8'd1;
                  cursor_x <= {1'b0, win_left};
                end
                read_data <= '0;
                done      <= 1'b1;
              end
              OP_RECT: begin
                op_q   <= OP_RECT;
                x_base <= {1'b0, pos_x};
                y      <= {2'b0, pos_y};
                w      <= fill_width;
                h      <= fill_height;
                on_q   <= pixel_on;
                if (fill_width == 8'd0) begin
                  read_data <= '0;
                  done      <= 1'b1;
                end else begin
                  state <= S_BAND;
                end
              end
              OP_READ: begin
                if (32'(read_address) < DEPTH) begin
                  state <= S_RDWAIT;
                end else begin
                  read_data <= '0;
                  done      <= 1'b1;
                end
              end
              default: begin
                read_data <= '0;
                done      <= 1'b1;
              end
            endcase
          end
        end
        S_BAND: begin
          if (h == 7'd0) begin
            // walk finished: apply the cursor rule of the command
            if (op_q == OP_PIXEL) begin
              if ((nx > {1'b0, win_right}) && (nx != {1'b0, win_left})) begin
                cursor_y <= cursor_y + 8'd1;
                cursor_x <= {1'b0, win_left};
              end else begin
                cursor_x <= nx;
              end
            end else if (op_q == OP_BAND) begin
              cursor_y <= y;
            end
            read_data <= '0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            mask <= band_mask;
            pg   <= PAGE_LUT[y[7:3]*PW +: PW];
            y    <= y + {4'd0, blk};
            h    <= h - {3'd0, blk};
            c    <= '0;
            if (w != 8'd0) begin
              state <= S_COL;
            end
          end
        end
        S_COL: begin
          // columns only grow, so the first one off the store ends the band
          if (col_in) begin
            wr_addr <= col_addr;
            state   <= S_WR;
          end else begin
            state <= S_BAND;
          end
        end
        S_WR: begin
          c <= c + 8'd1;
          if (c + 8'd1 == w) begin
            state <= S_BAND;
          end else begin
            state <= S_COL;
          end
        end
        S_RDWAIT: begin
          read_data <= rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (wr_en) begin
        unique case (cfg_reg_t'(wr_index))
          REG_WIN_LEFT: begin
            win_left <= wr_data;
            cursor_x <= {1'b0, wr_data};
          end
          REG_WIN_TOP: begin
            // the top row only reloads the cursor row
            cursor_y <= {2'b0, wr_data[5:0]};
          end
          REG_WIN_RIGHT: begin
            win_right <= wr_data;
          end
          REG_WIN_INVERT: begin
            win_invert <= wr_data[0];
          end
        endcase
      end
    end
  end

  a_ram_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WR))
    else $error("frame store written outside clear or write-back");

  a_wb_same_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (wr_addr == $past(rd_addr)))
    else $error("write-back address differs from the byte read");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("done beat while still busy");

  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (32'(wr_addr) < DEPTH))
    else $error("write-back address beyond the frame store");

endmodule

`default_nettype wire

// ===== sv/pfde_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
